[rtl/gcpr_pkg.sv]
// Shared types and constants for the GPIO change and periodic reporter.
// No dependencies; imported by every module of the block.
`default_nettype none

package gcpr_pkg;

  localparam int MaxCh   = 6;
  localparam int ModeW   = 6;
  localparam int ReloadW = 16;
  localparam int AddrW   = 5;
  localparam int DataW   = 32;
  localparam int ChanW   = 3;
  localparam int KindW   = 3;

  localparam logic [ModeW-1:0]   ModeReset   = 6'd25;
  localparam logic [ReloadW-1:0] ReloadReset = 16'd10;

  // Mode field layout
  localparam logic [1:0] TrigLevel = 2'd1;
  localparam logic [1:0] TrigRise  = 2'd2;
  localparam int BitMsg  = 2;
  localparam int BitLog  = 3;
  localparam int BitPmsg = 4;
  localparam int BitPlog = 5;

  // Report kinds
  localparam logic [KindW-1:0] KindOn       = 3'd0;
  localparam logic [KindW-1:0] KindOff      = 3'd1;
  localparam logic [KindW-1:0] KindPulse    = 3'd2;
  localparam logic [KindW-1:0] KindStateOn  = 3'd3;
  localparam logic [KindW-1:0] KindStateOff = 3'd4;

  // Register indexes (byte address / 4)
  localparam logic [2:0] RegReload = 3'd6;

  typedef logic [ModeW-1:0] mode_t;

  typedef enum logic {
    StIdle,
    StWalk
  } state_e;

  // Controller -> datapath
  typedef struct packed {
    logic load;     // tick transaction taken
    logic emit;     // current slot goes to the output register
    logic advance;  // move to the next slot
  } cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic primed;
    logic hit;        // current slot has a report
    logic at_end;     // current slot is the final one
    logic out_free;   // output register can take a result this cycle
    logic mask_empty; // no reports pending
  } sts_t;

endpackage

`default_nettype wire

[rtl/gcpr_ctrl.sv]
// Sequencer for the reporter: idle / slot walk state machine.
// Depends on gcpr_pkg.
`default_nettype none

module gcpr_ctrl import gcpr_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  sts_t      sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          // first tick after reset only records the sample
          if (sts_i.primed) state_d = StWalk;
        end
      end
      StWalk: begin
        cmd_o.emit    = sts_i.hit && sts_i.out_free;
        cmd_o.advance = !sts_i.hit || sts_i.out_free;
        if (cmd_o.advance && sts_i.at_end) state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/gcpr_dp.sv]
// Datapath: sample and period registers, report slot mask, output register.
// Depends on gcpr_pkg.
`default_nettype none

module gcpr_dp import gcpr_pkg::*; #(
  parameter int CHANNELS = MaxCh
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic [MaxCh-1:0]    sample_i,
  input  wire mode_t [MaxCh-1:0]   modes_i,
  input  wire logic [ReloadW-1:0]  reload_i,
  input  cmd_t                     cmd_i,
  output sts_t                     sts_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [ChanW-1:0]         channel_o,
  output logic [KindW-1:0]         kind_o,
  output logic                     sink_o,
  output logic                     level_o,
  output logic                     last_o
);

  localparam int SlotN = CHANNELS * 4;
  localparam int IdxW  = (CHANNELS > 1) ? $clog2(SlotN) : 3;
  localparam int ChW   = IdxW - 2;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SlotN - 1);

  logic [MaxCh-1:0]   sample_q;
  logic               primed_q;
  logic [ReloadW-1:0] cnt_q;
  logic [SlotN-1:0]   mask_q, mask_new, mask_rest;
  logic [IdxW-1:0]    idx_q;
  logic               out_valid_q;
  logic [ChanW-1:0]   channel_q;
  logic [KindW-1:0]   kind_q;
  logic               sink_q, level_q, last_q;

  logic [ReloadW-1:0] cnt_dec;
  logic               due;
  logic [ChW-1:0]     ch;
  logic [1:0]         slot;
  logic               now;
  mode_t              mode;
  logic [KindW-1:0]   kind_d;

  assign cnt_dec = cnt_q - 1'b1;
  assign due     = (cnt_dec == '0);

  // Per-channel report enables for this tick: msg, log, periodic msg, periodic log
  for (genvar c = 0; c < CHANNELS; c++) begin : g_mask
    logic now_c, was_c, det_c;
    assign now_c = sample_i[c];
    assign was_c = sample_q[c];
    assign det_c = ((modes_i[c][1:0] == TrigLevel) && (now_c != was_c)) ||
                   ((modes_i[c][1:0] == TrigRise) && !was_c && now_c);
    assign mask_new[4*c+0] = det_c && modes_i[c][BitMsg];
    assign mask_new[4*c+1] = det_c && modes_i[c][BitLog];
    assign mask_new[4*c+2] = due && modes_i[c][BitPmsg];
    assign mask_new[4*c+3] = due && modes_i[c][BitPlog];
  end

  assign ch        = idx_q[IdxW-1:2];
  assign slot      = idx_q[1:0];
  assign now       = sample_q[ch];
  assign mode      = modes_i[ch];
  assign mask_rest = mask_q & ~(SlotN'(1) << idx_q);

  always_comb begin
    if (!slot[1]) begin
      if (mode[1:0] == TrigLevel) kind_d = now ? KindOn : KindOff;
      else                         kind_d = KindPulse;
    end else begin
      kind_d = now ? KindStateOn : KindStateOff;
    end
  end

  assign sts_o.primed     = primed_q;
  assign sts_o.hit        = mask_q[idx_q];
  assign sts_o.at_end     = (idx_q == LastIdx);
  assign sts_o.out_free   = !out_valid_q || !out_stall_i;
  assign sts_o.mask_empty = (mask_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q    <= 1'b0;
      cnt_q       <= ReloadReset;
      mask_q      <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      sample_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        sample_q <= sample_i;
        primed_q <= 1'b1;
        idx_q    <= '0;
        if (primed_q) begin
          mask_q <= mask_new;
          cnt_q  <= due ? reload_i : cnt_dec;
        end else begin
          mask_q <= '0;
        end
      end else if (cmd_i.advance) begin
        idx_q <= idx_q + 1'b1;
        if (cmd_i.emit) mask_q <= mask_rest;
      end

      if (cmd_i.emit)        out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      channel_q <= ChanW'(ch);
      kind_q    <= kind_d;
      sink_q    <= slot[0];
      level_q   <= now;
      last_q    <= (mask_rest == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign channel_o   = channel_q;
  assign kind_o      = kind_q;
  assign sink_o      = sink_q;
  assign level_o     = level_q;
  assign last_o      = last_q;

endmodule

`default_nettype wire

[rtl/gpio_change_and_periodic_reporter.sv]
// Top level of the GPIO change and periodic reporter: APB register file,
// controller and datapath. Depends on gcpr_pkg, gcpr_ctrl, gcpr_dp.
//
//   Channel | Signals                          | Direction | Transaction
//   tick    | in_valid_i/in_stall_o, sample_i  | in        | valid & !stall
//   report  | out_valid_o/out_stall_i, fields  | out       | valid & !stall
//   config  | psel/penable/pwrite/paddr/pwdata | in        | psel&penable&pwrite
//
// A tick transaction is taken; the block then walks four report slots per
// channel, one slot per cycle unless a stalled output holds it. in_stall_o
// is high for the whole walk. A stalled output only holds the walk on a
// slot that has a report. The first tick after reset only records the
// sample. Reset is asynchronous, active low; no clearing pass.
`default_nettype none

module gpio_change_and_periodic_reporter import gcpr_pkg::*; #(
  parameter int CHANNELS = MaxCh
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  // tick input
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [MaxCh-1:0]  sample_i,
  // report output
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [ChanW-1:0]       channel_o,
  output logic [KindW-1:0]       kind_o,
  output logic                   sink_o,
  output logic                   level_o,
  output logic                   last_o,
  // configuration
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [AddrW-1:0]  paddr,
  input  wire logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]       prdata,
  output logic                   pready
);

  mode_t [MaxCh-1:0]  mode_q;
  logic [ReloadW-1:0] reload_q;
  logic [2:0]         reg_idx;
  logic               wr_en;
  cmd_t               cmd;
  sts_t               sts;

  // Register file: modes at 0x00..0x14, reload at 0x18
  assign pready  = 1'b1;
  assign reg_idx = paddr[AddrW-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= {MaxCh{ModeReset}};
      reload_q <= ReloadReset;
    end else if (wr_en) begin
      if (reg_idx < RegReload) mode_q[reg_idx] <= pwdata[ModeW-1:0];
      else if (reg_idx == RegReload) reload_q <= pwdata[ReloadW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx < RegReload)       prdata = DataW'(mode_q[reg_idx]);
    else if (reg_idx == RegReload) prdata = DataW'(reload_q);
  end

  gcpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  gcpr_dp #(
    .CHANNELS (CHANNELS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_i    (sample_i),
    .modes_i     (mode_q),
    .reload_i    (reload_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .channel_o   (channel_o),
    .kind_o      (kind_o),
    .sink_o      (sink_o),
    .level_o     (level_o),
    .last_o      (last_o)
  );

  // A report is never loaded over one still waiting behind a stall
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> sts.out_free)
    else $error("report loaded while output busy");

  // Walk finishes only after every pending report was issued
  a_walk_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_stall_o) |-> sts.mask_empty)
    else $error("walk ended with reports pending");

  // Priming tick produces no walk
  a_prime_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && !sts.primed) |=> (!in_stall_o && sts.primed))
    else $error("priming tick started a walk");

  // Only configured channels are reported
  a_chan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(channel_o) < CHANNELS))
    else $error("report for a channel out of range");

endmodule

`default_nettype wire
